// ===== rtl/core/ttd_pkg.sv =====
// ============================================================================
// ttd_pkg
// Shared types and constants of the touch tap / double tap detector.
// ============================================================================
package ttd_pkg;

   localparam int COORD_BITS    = 12;
   localparam int WINDOW_BITS   = 16;
   localparam int DIST_BITS     = 12;
   localparam int COUNT_BITS    = 4;
   localparam int CSR_IDX_BITS  = 2;
   localparam int CSR_DATA_BITS = 16;
   localparam int QUEUE_DEPTH   = 2;
   localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

   localparam int PT_DATA_BITS  = ((2 * COORD_BITS + 7) / 8) * 8;
   localparam int SUM_BITS      = 2 * COORD_BITS + 1;
   localparam int LIM_BITS      = 2 * DIST_BITS;
   localparam int DSQ_BITS      = (SUM_BITS > LIM_BITS) ? SUM_BITS : LIM_BITS;

   localparam logic [WINDOW_BITS-1:0] WINDOW_RESET = WINDOW_BITS'(300);
   localparam logic [DIST_BITS-1:0]   DIST_RESET   = DIST_BITS'(20);
   localparam logic [WINDOW_BITS-1:0] TIMER_MAX    = '1;
   localparam logic [COUNT_BITS-1:0]  COUNT_MAX    = '1;

   typedef enum logic [1:0] {
      CMD_DOWN   = 2'd0,
      CMD_UP     = 2'd1,
      CMD_TICK   = 2'd2,
      CMD_UNUSED = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      KIND_DOWN,
      KIND_UP,
      KIND_TICK
   } kind_type;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_TAP_WINDOW = 2'd0,
      CSR_MAX_DIST   = 2'd1
   } csr_index_type;

   typedef enum logic {
      GEST_SINGLE = 1'b0,
      GEST_DOUBLE = 1'b1
   } gesture_type;

   typedef struct packed {
      kind_type               kind;
      logic [COORD_BITS-1:0]  x;
      logic [COORD_BITS-1:0]  y;
   } item_type;

endpackage

// ===== rtl/core/ttd_front.sv =====
// ============================================================================
// ttd_front
// Accept words, decode the command into an event kind and hold it for the
// queue. Words with the unused command code are dropped here.
// ============================================================================
module ttd_front
   import ttd_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic [PT_DATA_BITS-1:0] req_tdata,
   input  logic [1:0]              req_tuser,
   output item_type                item,
   output logic                    push_valid,
   input  logic                    push_ready
);

   logic                   valid_ff;
   logic                   valid_in;
   item_type               item_ff;
   item_type               item_in;
   logic                   accept;
   logic                   keep;
   cmd_type                cmd;

   assign cmd        = cmd_type'(req_tuser);
   assign req_tready = !valid_ff || push_ready;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      keep         = 1'b1;
      item_in      = item_ff;
      item_in.x    = req_tdata[COORD_BITS-1:0];
      item_in.y    = req_tdata[2*COORD_BITS-1:COORD_BITS];
      case (cmd)
         CMD_DOWN: item_in.kind = KIND_DOWN;
         CMD_UP:   item_in.kind = KIND_UP;
         CMD_TICK: item_in.kind = KIND_TICK;
         default: begin
            item_in.kind = KIND_TICK;
            keep         = 1'b0;
         end
      endcase
   end

   always_comb begin
      valid_in = valid_ff;
      if (push_ready) begin
         valid_in = 1'b0;
      end
      if (accept) begin
         valid_in = keep;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (accept) begin
         item_ff <= item_in;
      end
   end

   assign item       = item_ff;
   assign push_valid = valid_ff;

endmodule

// ===== rtl/core/ttd_queue.sv =====
// ============================================================================
// ttd_queue
// Short FIFO between the decode front and the gesture back end.
// ============================================================================
module ttd_queue
   import ttd_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  item_type push_item,
   input  logic     push_valid,
   output logic     push_ready,
   output item_type pop_item,
   output logic     pop_valid,
   input  logic     pop_ready
);

   item_type                  mem_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0] wr_ptr_ff;
   logic [QUEUE_PTR_BITS-1:0] wr_ptr_in;
   logic [QUEUE_PTR_BITS-1:0] rd_ptr_ff;
   logic [QUEUE_PTR_BITS-1:0] rd_ptr_in;
   logic [QUEUE_CNT_BITS-1:0] count_ff;
   logic [QUEUE_CNT_BITS-1:0] count_in;
   logic                      do_push;
   logic                      do_pop;

   assign push_ready = count_ff != QUEUE_CNT_BITS'(QUEUE_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_item   = mem_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ===== rtl/core/ttd_back.sv =====
// ============================================================================
// ttd_back
// Gesture state, configuration registers and the result register. One
// queued event is applied per cycle while the result register can take it.
// ============================================================================
module ttd_back
   import ttd_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  item_type                item,
   input  logic                    item_valid,
   output logic                    item_ready,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [CSR_IDX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0] csr_data,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [PT_DATA_BITS-1:0] rsp_tdata,
   output logic                    rsp_tuser
);

   logic [WINDOW_BITS-1:0] window_ff;
   logic [LIM_BITS-1:0]    lim_sq_ff;
   logic [COUNT_BITS-1:0]  count_ff;
   logic [COUNT_BITS-1:0]  count_in;
   logic [COORD_BITS-1:0]  start_x_ff;
   logic [COORD_BITS-1:0]  start_y_ff;
   logic                   start_load;
   logic                   pending_ff;
   logic                   pending_in;
   logic [WINDOW_BITS-1:0] elapsed_ff;
   logic [WINDOW_BITS-1:0] elapsed_in;
   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   gesture_type            gesture_ff;
   gesture_type            gesture_in;
   logic [COORD_BITS-1:0]  tap_x_ff;
   logic [COORD_BITS-1:0]  tap_y_ff;
   logic                   emit;
   logic                   step;
   logic [COORD_BITS-1:0]  dx;
   logic [COORD_BITS-1:0]  dy;
   logic [SUM_BITS-1:0]    dist_sq;
   logic                   near;
   logic [DIST_BITS-1:0]   dist_val;

   assign csr_ready  = 1'b1;
   assign item_ready = !rsp_valid_ff || rsp_tready;
   assign step       = item_valid && item_ready;
   assign dist_val   = csr_data[DIST_BITS-1:0];

   // While a tap is pending its point equals the start point, so one
   // distance check serves both the start and the pending point.
   always_comb begin
      dx      = (start_x_ff > item.x) ? start_x_ff - item.x : item.x - start_x_ff;
      dy      = (start_y_ff > item.y) ? start_y_ff - item.y : item.y - start_y_ff;
      dist_sq = SUM_BITS'(dx * dx) + SUM_BITS'(dy * dy);
      near    = DSQ_BITS'(dist_sq) < DSQ_BITS'(lim_sq_ff);
   end

   always_comb begin
      count_in   = count_ff;
      pending_in = pending_ff;
      elapsed_in = elapsed_ff;
      start_load = 1'b0;
      emit       = 1'b0;
      gesture_in = GEST_SINGLE;
      case (item.kind)
         KIND_DOWN: begin
            if (count_ff != COUNT_MAX) begin
               count_in = count_ff + 1'b1;
            end
            if (count_in == COUNT_BITS'(1) && !pending_ff) begin
               start_load = 1'b1;
               elapsed_in = '0;
            end
         end
         KIND_UP: begin
            if (count_ff != '0) begin
               count_in = count_ff - 1'b1;
            end
            if (count_in == '0 && elapsed_ff < window_ff && near) begin
               if (!pending_ff) begin
                  pending_in = 1'b1;
               end else begin
                  pending_in = 1'b0;
                  emit       = 1'b1;
                  gesture_in = GEST_DOUBLE;
               end
            end
         end
         KIND_TICK: begin
            if (elapsed_ff != TIMER_MAX) begin
               elapsed_in = elapsed_ff + 1'b1;
            end
            if (pending_ff && elapsed_in > window_ff) begin
               pending_in = 1'b0;
               emit       = 1'b1;
            end
         end
         default: begin
            count_in = count_ff;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (step && emit) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff    <= WINDOW_RESET;
         lim_sq_ff    <= LIM_BITS'(DIST_RESET * DIST_RESET);
         count_ff     <= '0;
         start_x_ff   <= '0;
         start_y_ff   <= '0;
         pending_ff   <= 1'b0;
         elapsed_ff   <= TIMER_MAX;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            case (csr_index_type'(csr_index))
               CSR_TAP_WINDOW: window_ff <= csr_data[WINDOW_BITS-1:0];
               CSR_MAX_DIST:   lim_sq_ff <= dist_val * dist_val;
               default:        window_ff <= window_ff;
            endcase
         end
         if (step) begin
            count_ff   <= count_in;
            pending_ff <= pending_in;
            elapsed_ff <= elapsed_in;
            if (start_load) begin
               start_x_ff <= item.x;
               start_y_ff <= item.y;
            end
         end
         rsp_valid_ff <= rsp_valid_in;
      end
      if (step && emit) begin
         gesture_ff <= gesture_in;
         tap_x_ff   <= start_x_ff;
         tap_y_ff   <= start_y_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = gesture_ff;
   assign rsp_tdata  = PT_DATA_BITS'({tap_y_ff, tap_x_ff});

endmodule

// ===== rtl/core/touch_tap_double_tap_detector.sv =====
// ============================================================================
// touch_tap_double_tap_detector
// Tap and double tap recognizer for touch down, touch up and 1 ms tick words.
// ============================================================================
// Takes one word per cycle, back to back. A word passes the input register
// and the two-entry queue, and the back end puts any result in the result
// register. Every word but the unused command updates the gesture state; while
// a result waits the back end holds, and the queue and input register take up
// to three more words before req_tready drops.
// A result appears only for a double tap or an expired single tap, at the
// pending tap point. Configuration writes take effect at once; the user must
// make them while the block is idle, which it does not enforce. csr_index 0 is
// the tap window in ms, 1 the exclusive tap distance limit in pixels.
// ============================================================================
module touch_tap_double_tap_detector
   import ttd_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [PT_DATA_BITS-1:0]  req_tdata,   // pos_x, pos_y
   input  logic [1:0]               req_tuser,   // cmd
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [PT_DATA_BITS-1:0]  rsp_tdata,   // tap_x, tap_y
   output logic                     rsp_tuser,   // gesture
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [CSR_IDX_BITS-1:0]  csr_index,
   input  logic [CSR_DATA_BITS-1:0] csr_data
);

   item_type front_item;
   logic     front_valid;
   logic     front_ready;
   item_type queue_item;
   logic     queue_valid;
   logic     back_ready;

   ttd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .item       (front_item),
      .push_valid (front_valid),
      .push_ready (front_ready)
   );

   ttd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_item  (front_item),
      .push_valid (front_valid),
      .push_ready (front_ready),
      .pop_item   (queue_item),
      .pop_valid  (queue_valid),
      .pop_ready  (back_ready)
   );

   ttd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .item       (queue_item),
      .item_valid (queue_valid),
      .item_ready (back_ready),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

// ===== dv/touch_tap_double_tap_detector_checker.sv =====
// ============================================================================
// touch_tap_double_tap_detector_checker
// Watches the request, result and register channels of the tap detector,
// keeps its own copy of the gesture state and register values, predicts the
// tap results of every accepted word and compares them in order.
// ============================================================================
module touch_tap_double_tap_detector_checker
   import ttd_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   input  logic                     req_tready,
   input  logic [PT_DATA_BITS-1:0]  req_tdata,
   input  logic [1:0]               req_tuser,
   input  logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   input  logic [PT_DATA_BITS-1:0]  rsp_tdata,
   input  logic                     rsp_tuser,
   input  logic                     csr_valid,
   input  logic                     csr_ready,
   input  logic [CSR_IDX_BITS-1:0]  csr_index,
   input  logic [CSR_DATA_BITS-1:0] csr_data,
   output int                       errors,
   output int                       outstanding,
   output int                       taps_checked,
   output int                       doubles_checked
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      gesture_type           kind;
      logic [COORD_BITS-1:0] x;
      logic [COORD_BITS-1:0] y;
   } tap_rec_type;

   tap_rec_type             expected_taps[$];

   logic [WINDOW_BITS-1:0]  window_ms;
   logic [DIST_BITS-1:0]    dist_lim;
   logic [COUNT_BITS-1:0]   fingers;
   logic [COORD_BITS-1:0]   start_x;
   logic [COORD_BITS-1:0]   start_y;
   logic                    pend_valid;
   logic [COORD_BITS-1:0]   pend_x;
   logic [COORD_BITS-1:0]   pend_y;
   logic [WINDOW_BITS-1:0]  timer_ms;

   initial begin
      errors          = 0;
      outstanding     = 0;
      taps_checked    = 0;
      doubles_checked = 0;
   end

   function automatic bit is_close(logic [COORD_BITS-1:0] ax, logic [COORD_BITS-1:0] ay,
                                   logic [COORD_BITS-1:0] bx, logic [COORD_BITS-1:0] by);
      logic [COORD_BITS-1:0]  dx;
      logic [COORD_BITS-1:0]  dy;
      logic [2*COORD_BITS:0]  dsq;
      logic [2*DIST_BITS-1:0] lsq;
      dx  = (ax > bx) ? ax - bx : bx - ax;
      dy  = (ay > by) ? ay - by : by - ay;
      dsq = dx * dx + dy * dy;
      lsq = dist_lim * dist_lim;
      return dsq < lsq;
   endfunction

   task automatic emit_tap(gesture_type kind);
      expected_taps.push_back('{kind, pend_x, pend_y});
      pend_valid = 1'b0;
      pend_x     = '0;
      pend_y     = '0;
   endtask

   task automatic predict_word(cmd_type cmd, logic [COORD_BITS-1:0] px,
                               logic [COORD_BITS-1:0] py);
      case (cmd)
         CMD_DOWN: begin
            if (fingers != COUNT_MAX) fingers = fingers + 1'b1;
            if (fingers == 1 && !pend_valid) begin
               start_x  = px;
               start_y  = py;
               timer_ms = '0;
            end
         end
         CMD_UP: begin
            if (fingers != 0) fingers = fingers - 1'b1;
            if (fingers == 0 && timer_ms < window_ms &&
                is_close(start_x, start_y, px, py)) begin
               if (!pend_valid) begin
                  pend_valid = 1'b1;
                  pend_x     = start_x;
                  pend_y     = start_y;
               end else if (is_close(pend_x, pend_y, px, py)) begin
                  emit_tap(GEST_DOUBLE);
               end
            end
         end
         CMD_TICK: begin
            if (timer_ms != TIMER_MAX) timer_ms = timer_ms + 1'b1;
            if (pend_valid && timer_ms > window_ms) emit_tap(GEST_SINGLE);
         end
         default: ;
      endcase
   endtask

   task automatic check_result();
      tap_rec_type want;
      tap_rec_type got;
      got = '{gesture_type'(rsp_tuser), rsp_tdata[COORD_BITS-1:0],
              rsp_tdata[2*COORD_BITS-1:COORD_BITS]};
      if (expected_taps.size() == 0) begin
         errors++;
         if (errors <= 10)
            $display("%0t: tap result with none expected: kind %0d x %0d y %0d",
                     $realtime, got.kind, got.x, got.y);
      end else begin
         want = expected_taps.pop_front();
         taps_checked++;
         if (want.kind == GEST_DOUBLE) doubles_checked++;
         if (got.kind !== want.kind || got.x !== want.x || got.y !== want.y) begin
            errors++;
            if (errors <= 10)
               $display({"%0t: tap mismatch: expected kind %0d x %0d y %0d, ",
                         "got kind %0d x %0d y %0d"},
                        $realtime, want.kind, want.x, want.y, got.kind, got.x, got.y);
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         window_ms  = WINDOW_RESET;
         dist_lim   = DIST_RESET;
         fingers    = '0;
         start_x    = '0;
         start_y    = '0;
         pend_valid = 1'b0;
         pend_x     = '0;
         pend_y     = '0;
         timer_ms   = TIMER_MAX;
         expected_taps.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) check_result();
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_TAP_WINDOW: window_ms = csr_data[WINDOW_BITS-1:0];
               CSR_MAX_DIST:   dist_lim  = csr_data[DIST_BITS-1:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready)
            predict_word(cmd_type'(req_tuser), req_tdata[COORD_BITS-1:0],
                         req_tdata[2*COORD_BITS-1:COORD_BITS]);
      end
      outstanding = expected_taps.size();
   end

endmodule

// ===== dv/touch_tap_double_tap_detector_test.sv =====
// ============================================================================
// touch_tap_double_tap_detector_test
// Drives finger down, finger up, tick and unused words into the tap detector
// under several register settings and idle patterns: a directed opening on
// the edge cases, then random tap, double tap, multi-finger and noise
// sequences. The checker predicts and compares every tap result.
// ============================================================================
module touch_tap_double_tap_detector_test;
   timeunit 1ns;
   timeprecision 1ps;
   import ttd_pkg::*;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int DRAIN_CYCLES = 16;
   localparam int PHASES       = 8;
   localparam int PHASE_WORDS  = 240;
   localparam int COORD_TOP    = (1 << COORD_BITS) - 1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_SPARE = 2'd3;

   logic                     clock = 1'b0;
   logic                     reset;
   logic                     req_tvalid;
   logic                     req_tready;
   logic [PT_DATA_BITS-1:0]  req_tdata;   // pos_x, pos_y
   logic [1:0]               req_tuser;   // cmd
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic [PT_DATA_BITS-1:0]  rsp_tdata;   // tap_x, tap_y
   logic                     rsp_tuser;   // gesture
   logic                     csr_valid;
   logic                     csr_ready;
   logic [CSR_IDX_BITS-1:0]  csr_index;
   logic [CSR_DATA_BITS-1:0] csr_data;

   int errors;
   int outstanding;
   int taps_checked;
   int doubles_checked;

   int src_idle_pct   = 0;
   int sink_stall_pct = 0;
   int cur_window     = 300;
   int cur_dist       = 20;
   int words_sent     = 0;
   int settings_used  = 0;
   int cycles         = 0;

   logic [CSR_DATA_BITS-1:0] window_tab[PHASES] = '{16'd300, 16'd1, 16'hFFFF, 16'd5,
                                                    16'd12, 16'hFFFF, 16'd3, 16'd8};
   logic [CSR_DATA_BITS-1:0] dist_tab[PHASES]   = '{16'd20, 16'd4095, 16'd0, 16'd100,
                                                    16'd40, 16'd4095, 16'hF7D0, 16'd15};

   touch_tap_double_tap_detector u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   touch_tap_double_tap_detector_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .req_tuser       (req_tuser),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .rsp_tuser       (rsp_tuser),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .errors          (errors),
      .outstanding     (outstanding),
      .taps_checked    (taps_checked),
      .doubles_checked (doubles_checked)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(negedge clock) rsp_tready = ($urandom_range(99) >= sink_stall_pct);

   always @(posedge clock) begin
      cycles++;
      if (cycles == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d tap results still due", cycles, outstanding);
         $display("[touch_tap_double_tap_detector] ERROR");
         $finish;
      end
   end

   function automatic int clamp_coord(int v);
      if (v < 0) return 0;
      if (v > COORD_TOP) return COORD_TOP;
      return v;
   endfunction

   function automatic int near_coord(int c, int span);
      return clamp_coord(c + int'($urandom_range(2 * span)) - span);
   endfunction

   task automatic send_word(cmd_type cmd, int x, int y);
      while ($urandom_range(99) < src_idle_pct) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser  = cmd;
      req_tdata  = {COORD_BITS'(y), COORD_BITS'(x)};
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      words_sent++;
   endtask

   task automatic send_tick();
      send_word(CMD_TICK, $urandom_range(COORD_TOP), $urandom_range(COORD_TOP));
   endtask

   task automatic write_reg(logic [CSR_IDX_BITS-1:0] idx, logic [CSR_DATA_BITS-1:0] val);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data  = val;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid = 1'b0;
      if (idx == CSR_TAP_WINDOW) cur_window = val;
      else if (idx == CSR_MAX_DIST) cur_dist = val[DIST_BITS-1:0];
      settings_used++;
   endtask

   // hold the sender until every tap is back and the pipeline is empty
   task automatic quiesce();
      req_tvalid = 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic run_phase(int n_words);
      int stop_at;
      int x;
      int y;
      int span;
      int tick_cap;
      int nf;
      stop_at  = words_sent + n_words;
      span     = (cur_dist < 64) ? cur_dist + 2 : 64;
      tick_cap = (cur_window < 24) ? cur_window + 2 : 6;
      while (words_sent < stop_at) begin
         x = $urandom_range(COORD_TOP);
         y = $urandom_range(COORD_TOP);
         case ($urandom_range(9))
            0, 1, 2, 3, 4: begin
               send_word(CMD_DOWN, x, y);
               repeat ($urandom_range(2)) send_tick();
               send_word(CMD_UP, near_coord(x, span), near_coord(y, span));
               if ($urandom_range(2) != 0) begin
                  send_word(CMD_DOWN, near_coord(x, span), near_coord(y, span));
                  repeat ($urandom_range(1)) send_tick();
                  send_word(CMD_UP, near_coord(x, span), near_coord(y, span));
               end else begin
                  repeat ($urandom_range(tick_cap)) send_tick();
               end
            end
            5, 6: repeat ($urandom_range(1, tick_cap)) send_tick();
            7: begin
               nf = $urandom_range(2, 18);
               repeat (nf) send_word(CMD_DOWN, near_coord(x, span), near_coord(y, span));
               repeat (nf) send_word(CMD_UP, near_coord(x, span), near_coord(y, span));
            end
            default: send_word(cmd_type'(2'($urandom_range(3))), x, y);
         endcase
      end
   endtask

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = CMD_DOWN;
      csr_valid  = 1'b0;
      csr_index  = CSR_TAP_WINDOW;
      csr_data   = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // release with no finger down, unused command, lone tick
      send_word(CMD_UP, 5, 5);
      send_word(CMD_UNUSED, COORD_TOP, COORD_TOP);
      send_tick();
      // tap at the origin, double tap just inside the distance limit
      send_word(CMD_DOWN, 0, 0);
      send_word(CMD_UP, 0, 0);
      send_word(CMD_DOWN, 19, 0);
      send_word(CMD_UP, 19, 0);
      // tap at the far corner, release exactly at the limit, then double tap
      send_word(CMD_DOWN, COORD_TOP, COORD_TOP);
      send_word(CMD_UP, COORD_TOP, COORD_TOP);
      send_word(CMD_DOWN, COORD_TOP, COORD_TOP - 20);
      send_word(CMD_UP, COORD_TOP, COORD_TOP - 20);
      send_word(CMD_DOWN, COORD_TOP - 5, COORD_TOP - 5);
      send_word(CMD_UP, COORD_TOP - 5, COORD_TOP - 5);
      // two-finger tap, left pending
      send_word(CMD_DOWN, 100, 100);
      send_word(CMD_DOWN, 200, 200);
      send_word(CMD_UP, 200, 200);
      send_word(CMD_UP, 100, 100);
      // short window: pending tap expires into a single tap
      quiesce();
      write_reg(CSR_TAP_WINDOW, 16'd2);
      repeat (3) send_tick();
      // zero window: no release counts
      quiesce();
      write_reg(CSR_TAP_WINDOW, 16'd0);
      send_word(CMD_DOWN, 7, 7);
      send_word(CMD_UP, 7, 7);

      for (int p = 0; p < PHASES; p++) begin
         quiesce();
         case (p % 4)
            0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
            1: begin src_idle_pct = 73; sink_stall_pct = 0;  end
            2: begin src_idle_pct = 0;  sink_stall_pct = 73; end
            default: begin src_idle_pct = 11; sink_stall_pct = 11; end
         endcase
         write_reg(CSR_TAP_WINDOW, window_tab[p]);
         write_reg(CSR_MAX_DIST, dist_tab[p]);
         if (p == PHASES - 1) write_reg(CSR_SPARE, 16'hFFFF);
         run_phase(PHASE_WORDS);
      end

      quiesce();
      $display("covered %0d words across %0d register writes and four idle patterns",
               words_sent, settings_used);
      $display("checked %0d tap results, %0d double and %0d single, %0d errors",
               taps_checked, doubles_checked, taps_checked - doubles_checked, errors);
      if (errors == 0) begin
         $display("[touch_tap_double_tap_detector] OK");
      end else begin
         $display("[touch_tap_double_tap_detector] ERROR");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/core/ttd_pkg.sv
rtl/core/ttd_front.sv
rtl/core/ttd_queue.sv
rtl/core/ttd_back.sv
rtl/core/touch_tap_double_tap_detector.sv
dv/touch_tap_double_tap_detector_checker.sv
dv/touch_tap_double_tap_detector_test.sv
